// ----- rtl/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, constants and arithmetic helpers for the clamped polynomial
// detrender.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    localparam int unsigned VTX_STEPS = 37;   // serial vertex divide, one bit a cycle
    localparam int unsigned DIV_STEPS = 32;   // per-item scale divide stages

    typedef logic signed [31:0] t_q16;
    typedef logic signed [20:0] t_coef;

    localparam logic [2:0] REG_AVG_COEF = 3'd0;
    localparam logic [2:0] REG_STD_COEF = 3'd1;
    localparam logic [2:0] REG_AVG_LIM  = 3'd2;
    localparam logic [2:0] REG_STD_LIM  = 3'd3;
    localparam logic [2:0] REG_AVG_REF  = 3'd4;
    localparam logic [2:0] REG_STD_REF  = 3'd5;
    localparam logic [2:0] REG_ORDERS   = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO_LEAD = 2'd2;

    localparam t_q16 Q16_ONE = 32'sh0001_0000;
    localparam t_q16 Q16_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 Q16_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        PS_INIT,
        PS_DIV,
        PS_VTX,
        PS_MUL,
        PS_ACC,
        PS_FIN,
        PS_DONE
    } t_prep_state;

    typedef struct packed {
        logic  quad;
        t_coef top;
        t_coef mid;
        t_coef low;
        t_q16  lo;
        t_q16  hi;
    } t_poly_cfg;

    typedef struct packed {
        logic done;
        t_q16 flo_std;
        t_q16 fhi_std;
        t_q16 flo_avg;
        t_q16 fhi_avg;
    } t_prep_res;

    typedef struct packed {
        logic [31:0]        rem;
        logic [31:0]        nq;
        logic [31:0]        den;
        logic               neg;
        logic               ovf;
        logic               zero;
        logic signed [32:0] diff;
        logic signed [33:0] add;
    } t_dstage;

    function automatic t_q16 f_sat32(input logic signed [63:0] v);
        t_q16 r;
        if (v > 64'sd2147483647) begin
            r = Q16_MAX;
        end else if (v < -64'sd2147483648) begin
            r = Q16_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] f_mul32(input t_q16 a, input t_q16 b);
        return $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    endfunction

    // one Horner step: floor(prod / 2^16) + c * 16, saturated
    function automatic t_q16 f_horner(input logic signed [63:0] prod, input t_coef c);
        logic signed [63:0] s;
        s = (prod >>> 16) + $signed({{39{c[20]}}, c, 4'b0000});
        return f_sat32(s);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cpd_prep.sv -----
// ----------------------------------------------------------------------------
// cpd_prep
// Works out the flat range of both trend polynomials from the register set:
// serial vertex divide, then the polynomial at both limits on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  cpd_pkg::t_poly_cfg  i_std,
    input  cpd_pkg::t_poly_cfg  i_avg,
    output cpd_pkg::t_prep_res  o_res
);

    cpd_pkg::t_prep_state r_state, n_state;
    logic                 r_pp;
    logic                 r_pt;
    logic                 r_hk;
    logic [5:0]           r_dcnt;

    logic [36:0]          r_dn;
    logic [21:0]          r_drem;
    logic [36:0]          r_dq;
    cpd_pkg::t_q16        r_b;
    cpd_pkg::t_q16        r_y;
    logic signed [63:0]   r_prod;
    cpd_pkg::t_q16        r_ylo;
    cpd_pkg::t_q16        r_yhi;
    cpd_pkg::t_q16        r_flo_std, r_fhi_std, r_flo_avg, r_fhi_avg;

    cpd_pkg::t_poly_cfg   w_cfg;
    logic [20:0]          w_mag_mid;
    logic [20:0]          w_mag_top;
    logic [21:0]          w_div_d;
    logic [22:0]          w_t;
    logic [22:0]          w_tdif;
    logic                 w_ge;
    logic [21:0]          w_rem;
    logic                 w_bneg;
    cpd_pkg::t_q16        w_b;
    cpd_pkg::t_q16        w_lead;
    cpd_pkg::t_q16        w_xe;
    cpd_pkg::t_q16        w_acc;
    cpd_pkg::t_q16        w_flo;
    cpd_pkg::t_q16        w_fhi;

    assign w_cfg     = r_pp ? i_avg : i_std;
    assign w_mag_mid = w_cfg.mid[20] ? 21'(~w_cfg.mid + 21'd1) : w_cfg.mid;
    assign w_mag_top = w_cfg.top[20] ? 21'(~w_cfg.top + 21'd1) : w_cfg.top;
    assign w_div_d   = {w_mag_top, 1'b0};

    assign w_t    = {r_drem, r_dn[36]};
    assign w_tdif = w_t - {1'b0, w_div_d};
    assign w_ge   = (w_t >= {1'b0, w_div_d});
    assign w_rem  = w_ge ? w_tdif[21:0] : w_t[21:0];

    // vertex -(mid * 2^16) / (2 * top), truncated, saturated
    assign w_bneg = (w_cfg.mid[20] == w_cfg.top[20]);
    always_comb begin
        if (w_bneg) begin
            w_b = (r_dq > 37'd2147483648) ? cpd_pkg::Q16_MIN : (32'd0 - r_dq[31:0]);
        end else begin
            w_b = (r_dq > 37'd2147483647) ? cpd_pkg::Q16_MAX : r_dq[31:0];
        end
    end

    assign w_lead = $signed({{7{w_cfg.top[20]}}, w_cfg.top, 4'b0000});
    assign w_xe   = r_pt ? w_cfg.hi : w_cfg.lo;
    assign w_acc  = cpd_pkg::f_horner(r_prod, r_hk ? w_cfg.low : w_cfg.mid);

    always_comb begin
        if (!w_cfg.quad) begin
            w_flo = w_cfg.lo;
            w_fhi = w_cfg.hi;
        end else if (w_cfg.top[20] == (r_ylo > r_yhi)) begin
            w_flo = (r_b > w_cfg.lo) ? r_b : w_cfg.lo;
            w_fhi = w_cfg.hi;
        end else begin
            w_flo = w_cfg.lo;
            w_fhi = (r_b < w_cfg.hi) ? r_b : w_cfg.hi;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpd_pkg::PS_INIT: n_state = cpd_pkg::PS_DIV;
            cpd_pkg::PS_DIV: begin
                if (r_dcnt == 6'(cpd_pkg::VTX_STEPS - 1)) n_state = cpd_pkg::PS_VTX;
            end
            cpd_pkg::PS_VTX: n_state = cpd_pkg::PS_MUL;
            cpd_pkg::PS_MUL: n_state = cpd_pkg::PS_ACC;
            cpd_pkg::PS_ACC: begin
                n_state = (r_hk && r_pt) ? cpd_pkg::PS_FIN : cpd_pkg::PS_MUL;
            end
            cpd_pkg::PS_FIN: n_state = r_pp ? cpd_pkg::PS_DONE : cpd_pkg::PS_INIT;
            cpd_pkg::PS_DONE: n_state = cpd_pkg::PS_DONE;
            default: n_state = cpd_pkg::PS_INIT;
        endcase
        if (i_restart) n_state = cpd_pkg::PS_INIT;
    end

    // outputs
    always_comb begin
        o_res.done    = (r_state == cpd_pkg::PS_DONE);
        o_res.flo_std = r_flo_std;
        o_res.fhi_std = r_fhi_std;
        o_res.flo_avg = r_flo_avg;
        o_res.fhi_avg = r_fhi_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpd_pkg::PS_INIT;
            r_pp    <= 1'b0;
            r_pt    <= 1'b0;
            r_hk    <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (i_restart) begin
                r_pp <= 1'b0;
            end else begin
                case (r_state)
                    cpd_pkg::PS_INIT: r_dcnt <= '0;
                    cpd_pkg::PS_DIV:  r_dcnt <= r_dcnt + 6'd1;
                    cpd_pkg::PS_VTX: begin
                        r_pt <= 1'b0;
                        r_hk <= 1'b0;
                    end
                    cpd_pkg::PS_ACC: begin
                        if (!r_hk) begin
                            r_hk <= 1'b1;
                        end else if (!r_pt) begin
                            r_pt <= 1'b1;
                            r_hk <= 1'b0;
                        end
                    end
                    cpd_pkg::PS_FIN: r_pp <= ~r_pp;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cpd_pkg::PS_INIT: begin
                r_dn   <= {w_mag_mid, 16'd0};
                r_drem <= '0;
                r_dq   <= '0;
            end
            cpd_pkg::PS_DIV: begin
                r_dn   <= {r_dn[35:0], 1'b0};
                r_drem <= w_rem;
                r_dq   <= {r_dq[35:0], w_ge};
            end
            cpd_pkg::PS_VTX: begin
                r_b <= w_b;
                r_y <= w_lead;
            end
            cpd_pkg::PS_MUL: r_prod <= cpd_pkg::f_mul32(r_y, w_xe);
            cpd_pkg::PS_ACC: begin
                if (r_hk && !r_pt) begin
                    r_ylo <= w_acc;
                    r_y   <= w_lead;
                end else begin
                    r_y <= w_acc;
                    if (r_hk) begin
                        r_yhi <= w_acc;
                    end
                end
            end
            cpd_pkg::PS_FIN: begin
                if (r_pp) begin
                    r_flo_avg <= w_flo;
                    r_fhi_avg <= w_fhi;
                end else begin
                    r_flo_std <= w_flo;
                    r_fhi_std <= w_fhi;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/clamped_poly_detrend.sv -----
// ----------------------------------------------------------------------------
// clamped_poly_detrend
// Detrends a sample against clamped level and spread polynomials in a proxy.
//
//   port group        dir   handshake          payload
//   input samples     in    i_valid/o_ready    sample_value, proxy, station_average
//   results           out   o_valid/i_ready    detrended_value, status
//   registers         in    APB write/read     64-bit data, 8-byte spacing
//
// One transfer per cycle while o_ready is high; the scale divider has 32 stages.
// Reset and every register write start the flat-range preparation
// (37-step vertex divide and four multiply/accumulate pairs per polynomial)
// with o_ready low. The whole pipe holds while a result waits on i_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_poly_detrend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_proxy,
    input  logic signed [31:0] i_station_average,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [30:0]        o_detrended_value,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [62:0]          r_avg_coef, r_std_coef;
    logic [63:0]          r_avg_lim, r_std_lim;
    cpd_pkg::t_q16        r_avg_ref, r_std_ref;
    logic [1:0]           r_orders;

    logic                 w_cfg_wr;
    logic [2:0]           w_idx;
    cpd_pkg::t_poly_cfg   w_std_cfg, w_avg_cfg;
    cpd_pkg::t_prep_res   w_prep;
    logic [1:0]           w_std_err, w_avg_err, w_status;
    logic                 w_en;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_coef <= '0;
            r_std_coef <= '0;
            r_avg_lim  <= 64'h0001_0000_0000_0000;
            r_std_lim  <= 64'h0001_0000_0000_0000;
            r_avg_ref  <= '0;
            r_std_ref  <= cpd_pkg::Q16_ONE;
            r_orders   <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                cpd_pkg::REG_AVG_COEF: r_avg_coef <= pwdata[62:0];
                cpd_pkg::REG_STD_COEF: r_std_coef <= pwdata[62:0];
                cpd_pkg::REG_AVG_LIM:  r_avg_lim  <= pwdata;
                cpd_pkg::REG_STD_LIM:  r_std_lim  <= pwdata;
                cpd_pkg::REG_AVG_REF:  r_avg_ref  <= pwdata[31:0];
                cpd_pkg::REG_STD_REF:  r_std_ref  <= pwdata[31:0];
                cpd_pkg::REG_ORDERS:   r_orders   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cpd_pkg::REG_AVG_COEF: prdata = {1'b0, r_avg_coef};
            cpd_pkg::REG_STD_COEF: prdata = {1'b0, r_std_coef};
            cpd_pkg::REG_AVG_LIM:  prdata = r_avg_lim;
            cpd_pkg::REG_STD_LIM:  prdata = r_std_lim;
            cpd_pkg::REG_AVG_REF:  prdata = {32'd0, r_avg_ref};
            cpd_pkg::REG_STD_REF:  prdata = {32'd0, r_std_ref};
            cpd_pkg::REG_ORDERS:   prdata = {62'd0, r_orders};
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        w_std_cfg.quad = r_orders[1];
        w_std_cfg.top  = r_std_coef[62:42];
        w_std_cfg.mid  = r_std_coef[41:21];
        w_std_cfg.low  = r_std_coef[20:0];
        w_std_cfg.lo   = r_std_lim[31:0];
        w_std_cfg.hi   = r_std_lim[63:32];
        w_avg_cfg.quad = r_orders[0];
        w_avg_cfg.top  = r_avg_coef[62:42];
        w_avg_cfg.mid  = r_avg_coef[41:21];
        w_avg_cfg.low  = r_avg_coef[20:0];
        w_avg_cfg.lo   = r_avg_lim[31:0];
        w_avg_cfg.hi   = r_avg_lim[63:32];
    end

    // spread polynomial checked first
    always_comb begin
        if (w_std_cfg.hi <= w_std_cfg.lo) begin
            w_std_err = cpd_pkg::ST_LIMIT;
        end else if (w_std_cfg.quad && (w_std_cfg.top == '0)) begin
            w_std_err = cpd_pkg::ST_ZERO_LEAD;
        end else begin
            w_std_err = cpd_pkg::ST_OK;
        end
        if (w_avg_cfg.hi <= w_avg_cfg.lo) begin
            w_avg_err = cpd_pkg::ST_LIMIT;
        end else if (w_avg_cfg.quad && (w_avg_cfg.top == '0)) begin
            w_avg_err = cpd_pkg::ST_ZERO_LEAD;
        end else begin
            w_avg_err = cpd_pkg::ST_OK;
        end
        w_status = (w_std_err != cpd_pkg::ST_OK) ? w_std_err : w_avg_err;
    end

    cpd_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_wr),
        .i_std     (w_std_cfg),
        .i_avg     (w_avg_cfg),
        .o_res     (w_prep)
    );

    // ---------------- item pipeline ----------------
    logic                 r_ov;
    logic [30:0]          r_out_val;
    logic [1:0]           r_out_st;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en && w_prep.done;
    assign o_valid = r_ov;
    assign o_detrended_value = r_out_val;
    assign o_status = r_out_st;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v40, r_v41;

    cpd_pkg::t_q16        r_s1_v, r_s1_x, r_s1_avg;
    cpd_pkg::t_q16        r_s2_xs, r_s2_xa, r_s2_avg;
    logic signed [32:0]   r_s2_d;
    logic signed [63:0]   r_s3_ms, r_s3_ma;
    cpd_pkg::t_q16        r_s3_xs, r_s3_xa, r_s3_avg;
    logic signed [32:0]   r_s3_d;
    cpd_pkg::t_q16        r_s4_ys, r_s4_ya, r_s4_xs, r_s4_xa, r_s4_avg;
    logic signed [32:0]   r_s4_d;
    logic signed [63:0]   r_s5_ms, r_s5_ma;
    cpd_pkg::t_q16        r_s5_avg;
    logic signed [32:0]   r_s5_d;
    cpd_pkg::t_q16        r_s6_ps, r_s6_pa, r_s6_avg;
    logic signed [32:0]   r_s6_d;

    cpd_pkg::t_dstage     r_dv  [0:cpd_pkg::DIV_STEPS];
    cpd_pkg::t_dstage     n_dv  [0:cpd_pkg::DIV_STEPS];
    logic                 r_dvv [0:cpd_pkg::DIV_STEPS];

    cpd_pkg::t_q16        r_s40_scale;
    logic signed [32:0]   r_s40_d;
    logic signed [33:0]   r_s40_add;
    logic signed [64:0]   r_s41_mp;
    logic signed [33:0]   r_s41_add;

    cpd_pkg::t_q16        w_xs, w_xa, w_lead_s, w_lead_a, w_scale;
    logic [47:0]          w_nmag;
    logic [31:0]          w_psmag;
    logic [31:0]          w_q;
    logic signed [64:0]   w_mp_sh;
    logic signed [49:0]   w_sum;
    logic [30:0]          w_res;

    always_comb begin
        if (r_s1_x < w_prep.flo_std) begin
            w_xs = w_prep.flo_std;
        end else if (r_s1_x > w_prep.fhi_std) begin
            w_xs = w_prep.fhi_std;
        end else begin
            w_xs = r_s1_x;
        end
        if (r_s1_x < w_prep.flo_avg) begin
            w_xa = w_prep.flo_avg;
        end else if (r_s1_x > w_prep.fhi_avg) begin
            w_xa = w_prep.fhi_avg;
        end else begin
            w_xa = r_s1_x;
        end
    end

    // a linear polynomial runs as a quadratic with zero leading term
    assign w_lead_s = w_std_cfg.quad ? $signed({{7{w_std_cfg.top[20]}}, w_std_cfg.top, 4'b0000})
                                     : '0;
    assign w_lead_a = w_avg_cfg.quad ? $signed({{7{w_avg_cfg.top[20]}}, w_avg_cfg.top, 4'b0000})
                                     : '0;

    assign w_nmag  = r_std_ref[31] ? 48'(~{r_std_ref, 16'd0} + 48'd1) : {r_std_ref, 16'd0};
    assign w_psmag = r_s6_ps[31] ? (32'd0 - r_s6_ps) : r_s6_ps;

    // divider entry and restoring steps, one quotient bit per stage
    always_comb begin
        logic [32:0] t;
        logic [32:0] dif;
        logic        ge;
        n_dv[0].rem  = {16'd0, w_nmag[47:32]};
        n_dv[0].nq   = w_nmag[31:0];
        n_dv[0].den  = w_psmag;
        n_dv[0].neg  = r_std_ref[31] ^ r_s6_ps[31];
        n_dv[0].ovf  = ({16'd0, w_nmag[47:32]} >= w_psmag);
        n_dv[0].zero = (r_s6_ps == '0);
        n_dv[0].diff = r_s6_d;
        n_dv[0].add  = $signed({{2{r_s6_avg[31]}}, r_s6_avg})
                     + $signed({{2{r_avg_ref[31]}}, r_avg_ref})
                     - $signed({{2{r_s6_pa[31]}}, r_s6_pa});
        for (int j = 1; j <= cpd_pkg::DIV_STEPS; j++) begin
            t   = {r_dv[j-1].rem, r_dv[j-1].nq[31]};
            dif = t - {1'b0, r_dv[j-1].den};
            ge  = (t >= {1'b0, r_dv[j-1].den});
            n_dv[j]     = r_dv[j-1];
            n_dv[j].rem = ge ? dif[31:0] : t[31:0];
            n_dv[j].nq  = {r_dv[j-1].nq[30:0], ge};
        end
    end

    assign w_q = r_dv[cpd_pkg::DIV_STEPS].nq;
    always_comb begin
        if (r_dv[cpd_pkg::DIV_STEPS].zero) begin
            w_scale = cpd_pkg::Q16_ONE;
        end else if (r_dv[cpd_pkg::DIV_STEPS].neg) begin
            w_scale = (r_dv[cpd_pkg::DIV_STEPS].ovf || (w_q > 32'h8000_0000))
                    ? cpd_pkg::Q16_MIN : (32'd0 - w_q);
        end else begin
            w_scale = (r_dv[cpd_pkg::DIV_STEPS].ovf || w_q[31]) ? cpd_pkg::Q16_MAX : w_q;
        end
    end

    assign w_mp_sh = r_s41_mp >>> 16;
    assign w_sum   = $signed(w_mp_sh[49:0]) + $signed({{16{r_s41_add[33]}}, r_s41_add});
    always_comb begin
        if (w_sum[49]) begin
            w_res = '0;
        end else if (w_sum > 50'sd2147483647) begin
            w_res = '1;
        end else begin
            w_res = w_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v40 <= 1'b0;
            r_v41 <= 1'b0;
            r_ov  <= 1'b0;
            for (int j = 0; j <= cpd_pkg::DIV_STEPS; j++) r_dvv[j] <= 1'b0;
        end else if (w_en) begin
            r_v1     <= i_valid && o_ready;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_v6     <= r_v5;
            r_dvv[0] <= r_v6;
            for (int j = 1; j <= cpd_pkg::DIV_STEPS; j++) r_dvv[j] <= r_dvv[j-1];
            r_v40    <= r_dvv[cpd_pkg::DIV_STEPS];
            r_v41    <= r_v40;
            r_ov     <= r_v41;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_v   <= i_sample_value;
            r_s1_x   <= i_proxy;
            r_s1_avg <= i_station_average;

            r_s2_xs  <= w_xs;
            r_s2_xa  <= w_xa;
            r_s2_avg <= r_s1_avg;
            r_s2_d   <= $signed({r_s1_v[31], r_s1_v}) - $signed({r_s1_avg[31], r_s1_avg});

            r_s3_ms  <= cpd_pkg::f_mul32(w_lead_s, r_s2_xs);
            r_s3_ma  <= cpd_pkg::f_mul32(w_lead_a, r_s2_xa);
            r_s3_xs  <= r_s2_xs;
            r_s3_xa  <= r_s2_xa;
            r_s3_avg <= r_s2_avg;
            r_s3_d   <= r_s2_d;

            r_s4_ys  <= cpd_pkg::f_horner(r_s3_ms, w_std_cfg.mid);
            r_s4_ya  <= cpd_pkg::f_horner(r_s3_ma, w_avg_cfg.mid);
            r_s4_xs  <= r_s3_xs;
            r_s4_xa  <= r_s3_xa;
            r_s4_avg <= r_s3_avg;
            r_s4_d   <= r_s3_d;

            r_s5_ms  <= cpd_pkg::f_mul32(r_s4_ys, r_s4_xs);
            r_s5_ma  <= cpd_pkg::f_mul32(r_s4_ya, r_s4_xa);
            r_s5_avg <= r_s4_avg;
            r_s5_d   <= r_s4_d;

            r_s6_ps  <= cpd_pkg::f_horner(r_s5_ms, w_std_cfg.low);
            r_s6_pa  <= cpd_pkg::f_horner(r_s5_ma, w_avg_cfg.low);
            r_s6_avg <= r_s5_avg;
            r_s6_d   <= r_s5_d;

            for (int j = 0; j <= cpd_pkg::DIV_STEPS; j++) r_dv[j] <= n_dv[j];

            r_s40_scale <= w_scale;
            r_s40_d     <= r_dv[cpd_pkg::DIV_STEPS].diff;
            r_s40_add   <= r_dv[cpd_pkg::DIV_STEPS].add;

            r_s41_mp  <= $signed({{32{r_s40_d[32]}}, r_s40_d})
                       * $signed({{33{r_s40_scale[31]}}, r_s40_scale});
            r_s41_add <= r_s40_add;

            r_out_val <= (w_status != cpd_pkg::ST_OK) ? 31'd0 : w_res;
            r_out_st  <= w_status;
        end
    end

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cpd_pkg::ST_OK)) |-> (o_detrended_value == 31'd0))
        else $error("error status with nonzero value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == cpd_pkg::ST_OK || o_status == cpd_pkg::ST_LIMIT
                     || o_status == cpd_pkg::ST_ZERO_LEAD))
        else $error("undefined status code");

    a_wr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !o_ready)
        else $error("input open while flat ranges are stale");

    a_accept_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted transfer did not enter the pipe");

endmodule

`default_nettype wire

// ----- tb/cpd_checker.sv -----
// ----------------------------------------------------------------------------
// cpd_checker
// Watches the sample and result channels and the register port of the
// clamped polynomial detrender, predicts each result from its own copy of
// the registers and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_proxy,
    input  logic signed [31:0] i_station_average,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [30:0]        i_detrended_value,
    input  logic [1:0]         i_status,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [5:0]         i_paddr,
    input  logic [63:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [30:0] value;
        logic [1:0]  status;
    } t_result;

    t_result result_q[$];

    logic [62:0] avg_coef, std_coef;
    logic [63:0] avg_lim, std_lim;
    logic [31:0] avg_ref, std_ref;
    logic [1:0]  orders;
    int          mismatches;

    assign o_errors  = mismatches;
    assign o_pending = result_q.size();

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] poly_at(input logic signed [63:0] c2,
            input logic signed [63:0] c1, input logic signed [63:0] c0,
            input logic quad, input logic signed [63:0] x);
        logic signed [63:0] y;
        if (quad) begin
            y = c2 * 16;
            y = clip32((y * x >>> 16) + c1 * 16);
        end else begin
            y = c1 * 16;
        end
        return clip32((y * x >>> 16) + c0 * 16);
    endfunction

    function automatic logic signed [63:0] trend(input logic [62:0] packed_c,
            input logic quad, input logic [63:0] lim, input logic signed [63:0] x,
            inout logic [1:0] err);
        logic signed [63:0] lo, hi, c2, c1, c0, vtx, ylo, yhi, flo, fhi, xc;
        lo = 64'($signed(lim[31:0]));
        hi = 64'($signed(lim[63:32]));
        c2 = 64'($signed(packed_c[62:42]));
        c1 = 64'($signed(packed_c[41:21]));
        c0 = 64'($signed(packed_c[20:0]));
        if (hi <= lo) begin
            err = cpd_pkg::ST_LIMIT;
            return 0;
        end
        if (!quad) begin
            xc = x < lo ? lo : (x > hi ? hi : x);
            return poly_at(c2, c1, c0, 1'b0, xc);
        end
        if (c2 == 0) begin
            err = cpd_pkg::ST_ZERO_LEAD;
            return 0;
        end
        vtx = clip32(-(c1 * 65536) / (2 * c2));
        ylo = poly_at(c2, c1, c0, 1'b1, lo);
        yhi = poly_at(c2, c1, c0, 1'b1, hi);
        if ((c2 < 0) == (ylo > yhi)) begin
            flo = vtx > lo ? vtx : lo;
            fhi = hi;
        end else begin
            flo = lo;
            fhi = vtx < hi ? vtx : hi;
        end
        xc = x < flo ? flo : (x > fhi ? fhi : x);
        return poly_at(c2, c1, c0, 1'b1, xc);
    endfunction

    function automatic t_result detrend(input logic signed [31:0] v32,
            input logic signed [31:0] x32, input logic signed [31:0] a32);
        logic [1:0]         err;
        logic signed [63:0] ps, pa, scale, r, v, a;
        t_result            res;
        err = cpd_pkg::ST_OK;
        pa  = 0;
        v   = 64'(v32);
        a   = 64'(a32);
        ps  = trend(std_coef, orders[1], std_lim, 64'(x32), err);
        if (err == cpd_pkg::ST_OK) pa = trend(avg_coef, orders[0], avg_lim, 64'(x32), err);
        if (err != cpd_pkg::ST_OK) begin
            res.value  = '0;
            res.status = err;
            return res;
        end
        if (ps != 0) scale = clip32((64'($signed(std_ref)) * 65536) / ps);
        else scale = 65536;
        r = (((v - a) * scale) >>> 16) + a + 64'($signed(avg_ref)) - pa;
        if (r < 0) r = 0;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        res.value  = r[30:0];
        res.status = cpd_pkg::ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            avg_coef   <= '0;
            std_coef   <= '0;
            avg_lim    <= 64'h0001_0000_0000_0000;
            std_lim    <= 64'h0001_0000_0000_0000;
            avg_ref    <= '0;
            std_ref    <= 32'h0001_0000;
            orders     <= '0;
            mismatches <= 0;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    cpd_pkg::REG_AVG_COEF: avg_coef <= i_pwdata[62:0];
                    cpd_pkg::REG_STD_COEF: std_coef <= i_pwdata[62:0];
                    cpd_pkg::REG_AVG_LIM:  avg_lim  <= i_pwdata;
                    cpd_pkg::REG_STD_LIM:  std_lim  <= i_pwdata;
                    cpd_pkg::REG_AVG_REF:  avg_ref  <= i_pwdata[31:0];
                    cpd_pkg::REG_STD_REF:  std_ref  <= i_pwdata[31:0];
                    cpd_pkg::REG_ORDERS:   orders   <= i_pwdata[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                result_q.push_back(detrend(i_sample_value, i_proxy, i_station_average));
            if (i_out_valid && i_out_ready) begin
                got.value  = i_detrended_value;
                got.status = i_status;
                if (result_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result value=%h status=%0d", got.value,
                                 got.status);
                    mismatches <= mismatches + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got != want) begin
                        if (mismatches < 10)
                            $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                                     want.value, got.value, want.status, got.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_clamped_poly_detrend.sv -----
// ----------------------------------------------------------------------------
// tb_clamped_poly_detrend
// Drives samples through the detrender under a series of register settings,
// directed and random, with random gaps and stalls on both channels and a
// long result hold-off; the checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_clamped_poly_detrend;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_ready, o_valid, i_ready;
    logic signed [31:0] i_sample_value, i_proxy, i_station_average;
    logic [30:0]        o_detrended_value;
    logic [1:0]         o_status;
    logic               psel, penable, pwrite, pready;
    logic [5:0]         paddr;
    logic [63:0]        pwdata, prdata;
    int                 errors, pending;
    int                 cycles;
    logic               hold_req;
    logic signed [31:0] lim_lo, lim_hi;

    clamped_poly_detrend u_top (.*);

    cpd_checker u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_sample_value, .i_proxy, .i_station_average,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_detrended_value(o_detrended_value), .i_status(o_status),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (n = 0; n < 300; n++) @(negedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if ($urandom_range(9) < 3) begin
                n = gap_len();
                i_ready <= (n == 0);
                repeat (n) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input int idx, input logic [63:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 6'(idx * 8);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // assumes the caller is at a falling edge
    task automatic send_sample(input logic [31:0] v, input logic [31:0] x,
                               input logic [31:0] a, input logic gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample_value    <= v;
        i_proxy           <= x;
        i_station_average <= a;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // assumes the caller is at a falling edge
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(16 << 16))) - (8 << 16);
        endcase
    endfunction

    function automatic logic [20:0] rand_coef();
        case ($urandom_range(7))
            0: return 21'h0F_FFFF;
            1: return 21'h10_0000;
            2: return 21'($urandom);
            3: return '0;
            default: return 21'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    function automatic logic [31:0] rand_proxy();
        if ($urandom_range(3) == 0) return rand_word();
        return lim_lo + 32'($signed($urandom_range(64)) - 8) * ((lim_hi - lim_lo) >>> 4);
    endfunction

    task automatic random_setting();
        logic [63:0] lim;
        int i;
        lim_lo = 32'($signed($urandom_range(8 << 16))) - (4 << 16);
        lim_hi = lim_lo + 1 + 32'($urandom_range(6 << 16));
        for (i = 0; i < 2; i++) begin
            case ($urandom_range(11))
                0: lim = {lim_lo, lim_hi};
                1: lim = {$urandom, $urandom};
                2: lim = {32'h7FFF_FFFF, 32'h8000_0000};
                default: lim = {lim_hi, lim_lo};
            endcase
            reg_write(cpd_pkg::REG_AVG_LIM + i, lim);
        end
        reg_write(cpd_pkg::REG_AVG_COEF, {1'b0, rand_coef(), rand_coef(), rand_coef()});
        reg_write(cpd_pkg::REG_STD_COEF,
                  {1'($urandom_range(1)), rand_coef(), rand_coef(), rand_coef()});
        reg_write(cpd_pkg::REG_AVG_REF, {$urandom, rand_word()});
        reg_write(cpd_pkg::REG_STD_REF, {$urandom, rand_word()});
        reg_write(cpd_pkg::REG_ORDERS, {$urandom, $urandom});
    endtask

    initial begin
        int ph, k;
        cycles            = 0;
        hold_req          = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_sample_value    = '0;
        i_proxy           = '0;
        i_station_average = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        lim_lo            = 0;
        lim_hi            = cpd_pkg::Q16_ONE;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset setting: all-zero trends
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        drain();

        // quadratic, negative lead, both polynomials, vertex inside the range
        reg_write(cpd_pkg::REG_AVG_COEF, {21'h1F_F000, 21'h00_2000, 21'h00_0100});
        reg_write(cpd_pkg::REG_STD_COEF, {21'h1F_F000, 21'h00_2000, 21'h00_1000});
        reg_write(cpd_pkg::REG_AVG_LIM, {32'h0003_0000, 32'hFFFE_0000});
        reg_write(cpd_pkg::REG_STD_LIM, {32'h0003_0000, 32'hFFFE_0000});
        reg_write(cpd_pkg::REG_AVG_REF, 64'h0000_0000_0002_0000);
        reg_write(cpd_pkg::REG_STD_REF, 64'h0000_0000_0003_0000);
        reg_write(cpd_pkg::REG_ORDERS, 64'd3);
        reg_write(7, '1);
        for (k = -4; k <= 5; k++)
            send_sample(32'h0005_0000, 32'(k <<< 16), 32'h0001_0000, 1'b0);
        drain();
        // positive lead, the spread polynomial falling over the range
        reg_write(cpd_pkg::REG_STD_COEF, {21'h00_1000, 21'h1F_A000, 21'h00_0000});
        reg_write(cpd_pkg::REG_AVG_COEF, {21'h00_1000, 21'h00_2000, 21'h00_0000});
        for (k = -4; k <= 5; k++)
            send_sample(32'h0005_0000, 32'(k <<< 16), 32'h0001_0000, 1'b0);
        drain();
        // zero lead, then bad limits
        reg_write(cpd_pkg::REG_AVG_COEF, {21'h00_0000, 21'h00_2000, 21'h00_0000});
        send_sample(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        drain();
        reg_write(cpd_pkg::REG_STD_LIM, {32'h0001_0000, 32'h0001_0000});
        send_sample(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        drain();

        for (ph = 0; ph < 10; ph++) begin
            random_setting();
            @(negedge i_clk);
            for (k = 0; k < 75; k++) begin
                if (ph == 3 && k == 5) hold_req = 1'b1;
                send_sample(rand_word(), rand_proxy(), rand_word(), 1'b1);
            end
            drain();
        end

        repeat (150) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- clamped_poly_detrend.f -----
rtl/cpd_pkg.sv
rtl/cpd_prep.sv
rtl/clamped_poly_detrend.sv
tb/cpd_checker.sv
tb/tb_clamped_poly_detrend.sv
